// ----- src/heap_k_way_merge_assert.svh -----
// Assertion macros for the k-way merge heap block.
// Included inside module bodies that have clk and arst_n in scope.
`ifndef HEAP_K_WAY_MERGE_ASSERT_SVH
`define HEAP_K_WAY_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HKM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/hkm_pkg.sv -----
// Shared constants, codes and types of the k-way merge heap block.
// No dependencies; used by the interfaces and the top level.
package hkm_pkg;

	localparam int MAX_LISTS = 16;
	localparam int VALUE_W   = 32;
	localparam int LIST_W    = 4;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = $clog2(MAX_LISTS);
	localparam int CNT_W     = IDX_W + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_BUILD   = 2'd1,
		KIND_NEXT    = 2'd2,
		KIND_EXHAUST = 2'd3
	} hkm_kind_t;

	typedef enum logic [1:0] {
		OP_BUILD,
		OP_NEXT,
		OP_DROP
	} hkm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_GRAB,
		ST_RD_L,
		ST_RD_R,
		ST_CMP,
		ST_ROOT,
		ST_EMIT
	} hkm_state_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] val;
		logic [LIST_W-1:0]         lst;
	} hkm_entry_t;

endpackage

// ----- src/hkm_if.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on hkm_pkg for the field widths.
interface hkm_in_if;
	logic                              valid;
	logic                              ready;
	logic [hkm_pkg::KIND_W-1:0]        kind;
	logic [hkm_pkg::LIST_W-1:0]        list_id;
	logic signed [hkm_pkg::VALUE_W-1:0] value;

	modport source (output valid, kind, list_id, value, input ready);
	modport sink (input valid, kind, list_id, value, output ready);
endinterface

interface hkm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [hkm_pkg::VALUE_W-1:0] out_value;
	logic [hkm_pkg::LIST_W-1:0]        out_list;
	logic                              done_res;

	modport source (output valid, out_value, out_list, done_res, input ready);
	modport sink (input valid, out_value, out_list, done_res, output ready);
endinterface

// ----- src/hkm_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module hkm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/heap_k_way_merge.sv -----
// K-way merge engine: a binary min-heap of list heads kept in one synchronous RAM.
// Usage: words enter on in_ch (valid/ready), results leave on out_ch (valid/ready).
// A load word appends one list head and gives no result; loads
// past capacity or after the build word are dropped. A build word heapifies the
// stored heads bottom-up and returns the smallest head and its list number.
// A next word replaces the root value and sifts it down; an exhausted word moves
// the last entry to the root, shrinks the heap and sifts down. Both return the new
// minimum, or a done word once the heap is empty.
// Sift-down is paced by the single read port of the heap RAM: each level reads the
// two children one after the other, then compares and writes back the smaller child
// or the held entry. A build word sifts down each interior node, from the last one.
// Input is taken only between words; a finished result sits in an output register,
// so the next word is accepted while the receiver stalls. A word whose result finds
// that register still full waits until the receiver takes it.
// Reset clears the heap count and returns the block to the loading phase; the heap
// RAM is not cleared, as entries at or above the count are never used.
module heap_k_way_merge (
	input  logic      clk,
	input  logic      arst_n,
	hkm_in_if.sink    in_ch,
	hkm_out_if.source out_ch
);

	import hkm_pkg::*;

	hkm_state_t state_q, state_nx;
	hkm_op_t    op_q;

	logic [CNT_W-1:0] cnt_q;
	logic             merging_q;
	logic [CNT_W-1:0] i_q;
	logic [IDX_W-1:0] pos_q;
	logic signed [VALUE_W-1:0] val_q;
	hkm_entry_t cur_q;
	hkm_entry_t lch_q;
	logic       l_less_q;
	logic       r_ok_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [LIST_W-1:0]         out_list_q;
	logic                      done_q;

	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	hkm_entry_t       wr_entry, rd_entry;
	logic [$bits(hkm_entry_t)-1:0] rd_raw;

	logic             acc;
	logic             out_free;
	logic             room;
	logic             cnt_zero;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] i_dec;
	logic [IDX_W:0]   l_idx, r_idx;
	logic             l_ok, r_ok;
	hkm_entry_t       cand, grab;
	logic             r_less;
	hkm_state_t       end_st;

	logic             sifting;
	logic             done_out;
	logic             load_ok;
	logic [CNT_W-1:0] cnt_inc;

	hkm_ram #(
		.WIDTH($bits(hkm_entry_t)),
		.DEPTH(MAX_LISTS)
	) u_heap_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_entry = hkm_entry_t'(rd_raw);

	assign acc      = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign room     = cnt_q < CNT_W'(MAX_LISTS);
	assign cnt_zero = (cnt_q == '0);
	assign cnt_dec  = cnt_q - 1'b1;
	assign i_dec    = i_q - 1'b1;
	assign l_idx    = {pos_q, 1'b1};
	assign r_idx    = l_idx + 1'b1;
	assign l_ok     = l_idx < cnt_q;
	assign r_ok     = r_idx < cnt_q;
	assign cand     = l_less_q ? lch_q : cur_q;
	assign r_less   = r_ok_q && (rd_entry.val < cand.val);
	assign end_st   = (op_q == OP_BUILD) ? ST_BUILD : ST_ROOT;

	always_comb begin
		grab = rd_entry;
		if (op_q == OP_NEXT) begin
			grab.val = val_q;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_ch.kind)
						KIND_LOAD: state_nx = ST_IDLE;
						KIND_BUILD: state_nx = ST_BUILD;
						KIND_NEXT: begin
							if (merging_q) begin
								state_nx = cnt_zero ? ST_ROOT : ST_GRAB;
							end
						end
						KIND_EXHAUST: begin
							if (merging_q) begin
								// The last entry leaving empties the heap.
								state_nx = (cnt_q <= CNT_W'(1)) ? ST_ROOT : ST_GRAB;
							end
						end
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_BUILD: state_nx = (i_q == '0) ? ST_ROOT : ST_GRAB;
			ST_GRAB:  state_nx = ST_RD_L;
			ST_RD_L:  state_nx = l_ok ? ST_RD_R : end_st;
			ST_RD_R:  state_nx = ST_CMP;
			ST_CMP:   state_nx = (r_less || l_less_q) ? ST_RD_L : end_st;
			ST_ROOT:  state_nx = ST_EMIT;
			ST_EMIT:  state_nx = out_free ? ST_IDLE : ST_EMIT;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Outputs: handshake and RAM port control.
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_entry = cur_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_ch.kind)
						KIND_LOAD: begin
							if (!merging_q && room) begin
								wr_en        = 1'b1;
								wr_addr      = cnt_q[IDX_W-1:0];
								wr_entry.val = in_ch.value;
								wr_entry.lst = in_ch.list_id;
							end
						end
						KIND_NEXT: begin
							rd_en = merging_q && !cnt_zero;
						end
						KIND_EXHAUST: begin
							rd_en   = merging_q && !cnt_zero;
							rd_addr = cnt_dec[IDX_W-1:0];
						end
						default: rd_en = 1'b0;
					endcase
				end
			end
			ST_BUILD: begin
				rd_en   = (i_q != '0);
				rd_addr = i_dec[IDX_W-1:0];
			end
			ST_RD_L: begin
				if (l_ok) begin
					rd_en   = 1'b1;
					rd_addr = l_idx[IDX_W-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			ST_RD_R: begin
				rd_en   = r_ok;
				rd_addr = r_idx[IDX_W-1:0];
			end
			ST_CMP: begin
				// The smaller child moves up into the hole, or the held entry settles.
				wr_en    = 1'b1;
				wr_entry = r_less ? rd_entry : cand;
			end
			ST_ROOT: rd_en = 1'b1;
			ST_GRAB, ST_EMIT: rd_en = 1'b0;
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_BUILD;
			cnt_q       <= '0;
			merging_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && acc) begin
				case (in_ch.kind)
					KIND_LOAD: begin
						if (!merging_q && room) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					KIND_BUILD: begin
						merging_q <= 1'b1;
						op_q      <= OP_BUILD;
					end
					KIND_NEXT: op_q <= OP_NEXT;
					default: begin
						op_q <= OP_DROP;
						if (merging_q && !cnt_zero) begin
							cnt_q <= cnt_dec;
						end
					end
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					val_q <= in_ch.value;
					pos_q <= '0;
					i_q   <= cnt_q >> 1;
				end
			end
			ST_BUILD: begin
				pos_q <= i_dec[IDX_W-1:0];
				i_q   <= i_dec;
			end
			ST_GRAB: cur_q <= grab;
			ST_RD_R: begin
				lch_q    <= rd_entry;
				l_less_q <= rd_entry.val < cur_q.val;
				r_ok_q   <= r_ok;
			end
			ST_CMP: begin
				if (r_less) begin
					pos_q <= r_idx[IDX_W-1:0];
				end else if (l_less_q) begin
					pos_q <= l_idx[IDX_W-1:0];
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (cnt_zero) begin
						out_value_q <= '0;
						out_list_q  <= '0;
						done_q      <= 1'b1;
					end else begin
						out_value_q <= rd_entry.val;
						out_list_q  <= rd_entry.lst;
						done_q      <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_value = out_value_q;
	assign out_ch.out_list  = out_list_q;
	assign out_ch.done_res  = done_q;

	assign sifting  = (state_q == ST_RD_L) || (state_q == ST_RD_R) || (state_q == ST_CMP);
	assign done_out = out_ch.valid && out_ch.done_res;
	assign load_ok  = acc && (in_ch.kind == KIND_LOAD) && !merging_q && room;
	assign cnt_inc  = cnt_q + 1'b1;

	`include "heap_k_way_merge_assert.svh"

	`HKM_ASSERT_NOW(a_sift_pos_live, sifting, ({1'b0, pos_q} < cnt_q), "sift outside heap")
	`HKM_ASSERT_NOW(a_done_empty, done_out, (cnt_zero && merging_q), "done with a live heap")
	`HKM_ASSERT_NEXT(a_load_grows, load_ok, (cnt_q == $past(cnt_inc)), "load did not grow heap")

endmodule
